/* rtl/wtrm_pkg.sv */
// Shared types and constants for the windowed transfer rate meter.
// No dependencies.
`default_nettype none
package wtrm_pkg;
	localparam logic [1:0] REG_REPORT_INTERVAL = 2'd0;
	localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd1;
	localparam logic [1:0] REG_START_TIME      = 2'd2;
	localparam logic [1:0] REG_TOTAL_BYTES     = 2'd3;
	localparam logic [63:0] MS_PER_S = 64'd1000;

	// controller to datapath
	typedef struct packed {
		logic capture;    // latch the input item and do the fast work
		logic div_start;  // launch the divider
		logic [1:0] div_sel;
		logic take_q;     // store divider quotient into slot div_sel
		logic out_load;   // move results into the output register
	} wtrm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_busy;
		logic win_needed;
	} wtrm_sts_t;

	localparam logic [1:0] DIV_WIN  = 2'd0;
	localparam logic [1:0] DIV_AVG  = 2'd1;
	localparam logic [1:0] DIV_PMS  = 2'd2;
	localparam logic [1:0] DIV_LEFT = 2'd3;
endpackage
`default_nettype wire

/* rtl/wtrm_div.sv */
// Restoring 64-by-64 bit divider, one quotient bit per cycle.
// Uses no package.
`default_nettype none
module wtrm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic             busy,
	output logic [63:0]      quo
);
	logic [6:0]  cnt_q;
	logic [63:0] rem_q, quo_q, den_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};
	assign busy = (cnt_q != 7'd0);
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 64'd0;
			quo_q <= num;
			den_q <= den;
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/wtrm_datapath.sv */
// Datapath: registers, sample ring, divider operand selection, results.
// Depends on wtrm_pkg and wtrm_div.
`default_nettype none
module wtrm_datapath #(
	parameter int RING_DEPTH = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire wtrm_pkg::wtrm_cmd_t  cmd,
	output wtrm_pkg::wtrm_sts_t       sts,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_idx,
	input  wire logic [63:0]          cfg_data,
	output logic [63:0]               cfg_rdata,
	input  wire logic [1:0]           cfg_ridx,
	input  wire logic [159:0]         in_data,
	output logic [129:0]              out_data
);
	import wtrm_pkg::*;
	localparam int SW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 2);
	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
	localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);

	logic [31:0] report_int_q, sample_int_q, start_q, last_rep_q, held_q;
	logic [63:0] total_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] slot_q;
	logic [31:0] ring_t [RING_DEPTH];
	logic [63:0] ring_b [RING_DEPTH];

	logic [31:0] now, elapsed, last_t;
	logic [63:0] done, session;
	logic        report, store;
	logic [SW-1:0] prev_slot, next_slot, old_slot;
	logic [CW-1:0] count_nx;

	// latched item and results
	logic [31:0] elapsed_q, avg_q, left_q, pms_q;
	logic [63:0] sess_q, done_q, dbytes_q;
	logic [31:0] dtime_q;
	logic        stored_q, rep_q, win_q;

	logic        div_busy;
	logic [63:0] div_num, div_den, div_quo;

	assign now     = in_data[31:0];
	assign done    = in_data[95:32];
	assign session = in_data[159:96];
	assign elapsed = now - start_q;
	assign report  = (now - last_rep_q) > report_int_q;
	assign prev_slot = (slot_q == '0) ? LAST_SLOT : slot_q - SW'(1);
	assign next_slot = (slot_q == LAST_SLOT) ? '0 : slot_q + SW'(1);
	assign last_t  = ring_t[prev_slot];
	assign store   = !((count_q > DEPTH_C) && ((now - last_t) < sample_int_q));
	assign count_nx = (count_q <= DEPTH_C) ? count_q + CW'(1) : count_q;
	// oldest entry is the slot about to be overwritten once the ring is full
	assign old_slot = (count_nx >= DEPTH_C) ? next_slot : '0;

	always_comb begin
		case (cfg_ridx)
			REG_REPORT_INTERVAL: cfg_rdata = {32'd0, report_int_q};
			REG_SAMPLE_INTERVAL: cfg_rdata = {32'd0, sample_int_q};
			REG_START_TIME:      cfg_rdata = {32'd0, start_q};
			default:             cfg_rdata = total_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_int_q <= '0; sample_int_q <= '0; start_q <= '0; total_q <= '0;
			last_rep_q <= '0; held_q <= '0; count_q <= '0; slot_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_REPORT_INTERVAL: report_int_q <= cfg_data[31:0];
				REG_SAMPLE_INTERVAL: sample_int_q <= cfg_data[31:0];
				REG_START_TIME: begin
					start_q <= cfg_data[31:0]; last_rep_q <= cfg_data[31:0];
					count_q <= '0; slot_q <= '0; held_q <= '0;
				end
				default: total_q <= cfg_data;
			endcase
		end else begin
			if (cmd.capture) begin
				if (report) last_rep_q <= now;
				if (store) begin
					slot_q <= next_slot;
					count_q <= count_nx;
				end
			end
			if (cmd.take_q && cmd.div_sel == DIV_WIN) held_q <= div_quo[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (store) begin
				ring_t[slot_q] <= now;
				ring_b[slot_q] <= done;
			end
			elapsed_q <= elapsed;
			sess_q <= session;
			done_q <= done;
			stored_q <= store;
			rep_q <= report;
			win_q <= store && (count_nx > CW'(1));
			dbytes_q <= done - ring_b[old_slot];
			dtime_q <= now - ring_t[old_slot];
		end
		if (cmd.take_q) begin
			case (cmd.div_sel)
				DIV_AVG: avg_q <= div_quo[31:0];
				DIV_PMS: pms_q <= (div_quo[31:0] == 32'd0) ? 32'd1 : div_quo[31:0];
				DIV_LEFT: left_q <= div_quo[31:0];
				default: ;
			endcase
		end
		if (cmd.out_load)
			out_data <= {elapsed_q, left_q, avg_q, held_q, rep_q, stored_q};
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_WIN: begin
				div_num = dbytes_q * MS_PER_S;
				div_den = {32'd0, (dtime_q == 32'd0) ? 32'd1 : dtime_q};
			end
			DIV_AVG: begin
				div_num = sess_q * MS_PER_S;
				div_den = {32'd0, (elapsed_q == 32'd0) ? 32'd1 : elapsed_q};
			end
			DIV_PMS: begin
				div_num = sess_q;
				div_den = {32'd0, (elapsed_q == 32'd0) ? 32'd1 : elapsed_q};
			end
			default: begin
				div_num = total_q - done_q;
				div_den = {32'd0, pms_q};
			end
		endcase
	end

	wtrm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(div_num), .den(div_den), .busy(div_busy), .quo(div_quo)
	);

	assign sts.div_busy = div_busy;
	assign sts.win_needed = win_q;
endmodule
`default_nettype wire

/* rtl/wtrm_ctrl.sv */
// Controller: sequences capture, up to four divisions (the window division is skipped when not needed) and result load.
// Depends on wtrm_pkg.
`default_nettype none
module wtrm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire wtrm_pkg::wtrm_sts_t sts,
	output wtrm_pkg::wtrm_cmd_t      cmd
);
	import wtrm_pkg::*;
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LAUNCH = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_LOAD = 5'b01000,
		ST_HOLD = 5'b10000
	} state_t;
	state_t state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic valid_q, valid_d;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = valid_q;

	always_comb begin
		state_d = state_q; sel_d = sel_q; valid_d = valid_q;
		cmd = '0; cmd.div_sel = sel_q;
		if (valid_q && out_ready) valid_d = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				cmd.capture = 1'b1; state_d = ST_LAUNCH; sel_d = DIV_WIN;
			end
			ST_LAUNCH: begin
				if (sel_q == DIV_WIN && !sts.win_needed) begin
					sel_d = DIV_AVG;
				end else begin
					cmd.div_start = 1'b1; state_d = ST_WAIT;
				end
			end
			ST_WAIT: if (!sts.div_busy) begin
				cmd.take_q = 1'b1;
				if (sel_q == DIV_LEFT) state_d = ST_LOAD;
				else begin sel_d = sel_q + 2'd1; state_d = ST_LAUNCH; end
			end
			ST_LOAD: if (!valid_d) begin
				cmd.out_load = 1'b1; valid_d = 1'b1; state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; sel_q <= DIV_WIN; valid_q <= 1'b0;
		end else begin
			state_q <= state_d; sel_q <= sel_d; valid_q <= valid_d;
		end
	end
endmodule
`default_nettype wire

/* rtl/windowed_transfer_rate_meter.sv */
// Windowed transfer rate meter, top level. Depends on wtrm_pkg, wtrm_ctrl, wtrm_datapath.
// Each item is captured, then up to four divisions run in turn on one shared restoring
// divider, then the results are loaded; the window division is skipped when the window
// speed is not recomputed. A new item is accepted only after the last result is loaded.
// The output register lets the next item start while a result waits.
// Reset: arst_n asynchronously clears the control, configuration and ring bookkeeping
// registers; result, ring and divider data registers are not reset, and no value read
// from an unwritten ring entry is used.
`default_nettype none
module windowed_transfer_rate_meter #(
	parameter int RING_DEPTH = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [159:0] s_tdata,  // now_ms[31:0], done_bytes[95:32], session_bytes[159:96]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// sample_stored[0], report_due[1], window_speed[33:2], average_speed[65:34],
	// time_left[97:66], elapsed_ms[129:98], zero fill to 136
	output logic [135:0]      m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);
	import wtrm_pkg::*;
	wtrm_cmd_t cmd;
	wtrm_sts_t sts;
	logic [129:0] res;
	logic cfg_we;

	// registers at 8-byte strides; paddr[4:3] selects one of the four
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign m_tdata = {6'd0, res};

	wtrm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .cmd(cmd)
	);

	wtrm_datapath #(.RING_DEPTH(RING_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(paddr[4:3]), .cfg_data(pwdata),
		.cfg_rdata(prdata), .cfg_ridx(paddr[4:3]),
		.in_data(s_tdata), .out_data(res)
	);
endmodule
`default_nettype wire

/* rtl/wtrm_checker.sv */
// Port-level checker for the rate meter, bound to the top level.
// Depends on windowed_transfer_rate_meter only through the bind.
`default_nettype none
module wtrm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [135:0] m_tdata
);
	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("ready held after accept");
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid)) else $error("result too early");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[135:130] == 6'd0) else $error("fill bits set");
endmodule
bind windowed_transfer_rate_meter wtrm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
